FILE: hw/rtl/rq1b_pkg.sv
// ----------------------------------------------------------------------------
// Rotated Q1 basis evaluator package
// Payload types and shared constants for the rotated trilinear basis block.
// ----------------------------------------------------------------------------
package rq1b_pkg;

  typedef logic signed [15:0] point_t;
  typedef logic signed [31:0] jinv_t;
  typedef logic signed [15:0] value_t;
  typedef logic signed [31:0] grad_t;
  typedef logic        [2:0]  index_t;

  localparam int unsigned NUM_BASIS = 6;

endpackage

FILE: hw/rtl/rq1b_item_if.sv
// ----------------------------------------------------------------------------
// Rotated Q1 basis evaluator input channel
// Valid/ready channel that carries one reference point and inverse Jacobian.
// ----------------------------------------------------------------------------
interface rq1b_item_if;

  logic            valid;
  logic            ready;
  rq1b_pkg::point_t point_x;
  rq1b_pkg::point_t point_y;
  rq1b_pkg::point_t point_z;
  rq1b_pkg::jinv_t  jinv_00;
  rq1b_pkg::jinv_t  jinv_01;
  rq1b_pkg::jinv_t  jinv_02;
  rq1b_pkg::jinv_t  jinv_10;
  rq1b_pkg::jinv_t  jinv_11;
  rq1b_pkg::jinv_t  jinv_12;
  rq1b_pkg::jinv_t  jinv_20;
  rq1b_pkg::jinv_t  jinv_21;
  rq1b_pkg::jinv_t  jinv_22;

  modport source (
    output valid, point_x, point_y, point_z,
    output jinv_00, jinv_01, jinv_02, jinv_10, jinv_11, jinv_12,
    output jinv_20, jinv_21, jinv_22,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z,
    input  jinv_00, jinv_01, jinv_02, jinv_10, jinv_11, jinv_12,
    input  jinv_20, jinv_21, jinv_22,
    output ready
  );

endinterface

FILE: hw/rtl/rq1b_result_if.sv
// ----------------------------------------------------------------------------
// Rotated Q1 basis evaluator result channel
// Valid/ready channel that carries one basis value and physical gradient.
// ----------------------------------------------------------------------------
interface rq1b_result_if;

  logic             valid;
  logic             ready;
  rq1b_pkg::index_t basis_index;
  rq1b_pkg::value_t basis_value;
  rq1b_pkg::grad_t  grad_x;
  rq1b_pkg::grad_t  grad_y;
  rq1b_pkg::grad_t  grad_z;
  logic             last_basis;

  modport source (
    output valid, basis_index, basis_value, grad_x, grad_y, grad_z, last_basis,
    input  ready
  );

  modport sink (
    input  valid, basis_index, basis_value, grad_x, grad_y, grad_z, last_basis,
    output ready
  );

endinterface

FILE: hw/rtl/rotated_q1_basis_eval_3d_core.sv
// ----------------------------------------------------------------------------
// Rotated Q1 basis evaluator
// Evaluates the six face basis functions of the rotated trilinear element
// and maps their reference gradients through the inverse Jacobian.
//
// Each transfer on the item channel carries a reference point and an inverse
// Jacobian. The block returns six transfers on the result channel, basis 0
// to 5, with last_basis set on the sixth. An item register feeds a
// seven-stage result pipeline one basis function per cycle while the
// receiver is ready, so the result channel is the bottleneck, and the
// next item is taken while the previous one is still in the pipeline. The
// first result of an item passes from the item register through stages 1 to 7.
// The cfg write port sets basis_mode (0 point variant, 1 mean variant);
// the user must change it only while the block is idle; the block does not enforce this.
// Reset clears the item valid flag and basis counter, the pipeline valid bits and basis_mode.
// When the receiver stalls, the whole pipeline holds; the item register
// still takes a new item while it is empty.
// ----------------------------------------------------------------------------
module rotated_q1_basis_eval_3d_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  rq1b_item_if.sink            item,
  rq1b_result_if.source        result
);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  localparam rq1b_pkg::index_t LAST_K = rq1b_pkg::index_t'(rq1b_pkg::NUM_BASIS - 1);
  localparam logic [32:0] DIV_CAP   = 33'h1_8000_0000;
  localparam logic [32:0] RECIP3    = 33'h1_5555_5556;
  localparam logic [31:0] GRAD_MAXQ = 32'h7FFF_FFFF;
  localparam logic [31:0] GRAD_MINQ = 32'h8000_0000;
  localparam logic [31:0] VAL_MAXQ  = 32'd32767;
  localparam logic [31:0] VAL_MINQ  = 32'd32768;

  function automatic axis_t face_axis(input rq1b_pkg::index_t k);
    axis_t a;
    unique case (k)
      3'd0, 3'd5: a = AXIS_Z;
      3'd1, 3'd4: a = AXIS_Y;
      default:    a = AXIS_X;
    endcase
    return a;
  endfunction

  function automatic logic [32:0] cap_div(input logic [37:0] x);
    logic [32:0] r;
    if (x > 38'(DIV_CAP)) begin
      r = DIV_CAP;
    end else begin
      r = x[32:0];
    end
    return r;
  endfunction

  // Exact floor(x / 3) for x below 2^33.
  function automatic logic [31:0] div3(input logic [32:0] x);
    logic [65:0] prod;
    prod = {33'b0, x} * {33'b0, RECIP3};
    return prod[65:34];
  endfunction

  logic basis_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_mode <= 1'b0;
    end else if (cfg_we) begin
      basis_mode <= cfg_wdata;
    end
  end

  // Item register and basis sequencer.
  logic             item_valid;
  rq1b_pkg::index_t k_cnt;
  rq1b_pkg::point_t p_reg [3];
  rq1b_pkg::jinv_t  jm_reg [9];
  logic             en;
  logic             take;
  logic [7:1]       vld;

  assign en         = !vld[7] || result.ready;
  assign item.ready = !rst && (!item_valid || (en && (k_cnt == LAST_K)));
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      k_cnt      <= '0;
    end else if (take) begin
      item_valid <= 1'b1;
      k_cnt      <= '0;
    end else if (item_valid && en) begin
      if (k_cnt == LAST_K) begin
        item_valid <= 1'b0;
        k_cnt      <= '0;
      end else begin
        k_cnt <= k_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_reg[0]  <= item.point_x;
      p_reg[1]  <= item.point_y;
      p_reg[2]  <= item.point_z;
      jm_reg[0] <= item.jinv_00;
      jm_reg[1] <= item.jinv_01;
      jm_reg[2] <= item.jinv_02;
      jm_reg[3] <= item.jinv_10;
      jm_reg[4] <= item.jinv_11;
      jm_reg[5] <= item.jinv_12;
      jm_reg[6] <= item.jinv_20;
      jm_reg[7] <= item.jinv_21;
      jm_reg[8] <= item.jinv_22;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], item_valid};
    end
  end

  // Issue logic: squares, signed axis coordinate and reference gradient.
  axis_t              cur_axis;
  logic               cur_neg;
  logic signed [31:0] sq_full [3];
  logic signed [18:0] g_cur [3];
  logic signed [16:0] sp_cur;

  always_comb begin
    logic signed [18:0] p19;
    logic signed [18:0] kon_p;
    logic signed [18:0] koff_p;
    cur_axis = face_axis(k_cnt);
    cur_neg  = (k_cnt < 3'd3);
    for (int c = 0; c < 3; c++) begin
      sq_full[c] = p_reg[c] * p_reg[c];
      p19        = 19'(p_reg[c]);
      kon_p      = basis_mode ? (p19 <<< 2) + (p19 <<< 1) : (p19 <<< 2);
      koff_p     = basis_mode ? -((p19 <<< 1) + p19) : -(p19 <<< 1);
      if (cur_axis == axis_t'(c[1:0])) begin
        g_cur[c] = (cur_neg ? -19'sd49152 : 19'sd49152) + kon_p;
      end else begin
        g_cur[c] = koff_p;
      end
    end
    unique case (cur_axis)
      AXIS_Y:  sp_cur = 17'(p_reg[1]);
      AXIS_Z:  sp_cur = 17'(p_reg[2]);
      default: sp_cur = 17'(p_reg[0]);
    endcase
    if (cur_neg) begin
      sp_cur = -sp_cur;
    end
  end

  // Pipeline registers.
  rq1b_pkg::index_t   k_pipe [1:6];
  axis_t              e1_axis;
  logic [30:0]        e1_sq [3];
  logic signed [16:0] e1_sp;
  logic signed [18:0] e1_g [3];
  rq1b_pkg::jinv_t    e1_jm [9];

  logic signed [50:0] e2_prod [3][3];
  logic signed [32:0] e2_rot;
  logic signed [35:0] e2_base;

  logic signed [52:0] e3_acc [3];
  logic signed [35:0] e3_num;

  logic [52:0]        e4_gmag [3];
  logic [2:0]         e4_gneg;
  logic [35:0]        e4_vmag;
  logic               e4_vneg;

  logic [32:0]        e5_gx [3];
  logic [2:0]         e5_gneg;
  logic [32:0]        e5_vx;
  logic               e5_vneg;

  logic [31:0]        e6_gq [3];
  logic [2:0]         e6_gneg;
  logic [31:0]        e6_vq;
  logic               e6_vneg;

  logic signed [32:0] sqa;
  logic signed [32:0] sqb;
  logic signed [32:0] sqc;
  logic signed [35:0] rot36;
  logic signed [35:0] sp36;
  logic [52:0]        gsum [3];
  logic [35:0]        vsum;

  always_comb begin
    unique case (e1_axis)
      AXIS_Y: begin
        sqa = $signed({2'b00, e1_sq[1]});
        sqb = $signed({2'b00, e1_sq[0]});
        sqc = $signed({2'b00, e1_sq[2]});
      end
      AXIS_Z: begin
        sqa = $signed({2'b00, e1_sq[2]});
        sqb = $signed({2'b00, e1_sq[0]});
        sqc = $signed({2'b00, e1_sq[1]});
      end
      default: begin
        sqa = $signed({2'b00, e1_sq[0]});
        sqb = $signed({2'b00, e1_sq[1]});
        sqc = $signed({2'b00, e1_sq[2]});
      end
    endcase
    sp36  = 36'(e1_sp);
    rot36 = 36'(e2_rot);
    for (int r = 0; r < 3; r++) begin
      gsum[r] = e4_gmag[r] + 53'd49152;
    end
    vsum = e4_vmag + 36'd98304;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: squares and reference gradient.
      k_pipe[1] <= k_cnt;
      e1_axis   <= cur_axis;
      e1_sp     <= sp_cur;
      for (int c = 0; c < 3; c++) begin
        e1_sq[c] <= sq_full[c][30:0];
        e1_g[c]  <= g_cur[c];
      end
      for (int i = 0; i < 9; i++) begin
        e1_jm[i] <= jm_reg[i];
      end

      // Stage 2: Jacobian products and quadratic correction.
      k_pipe[2] <= k_pipe[1];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          e2_prod[r][c] <= e1_jm[3 * r + c] * e1_g[c];
        end
      end
      e2_rot  <= (sqa <<< 1) - sqb - sqc;
      e2_base <= 36'sd536870912 + sp36 * 36'sd98304;

      // Stage 3: row sums and value numerator.
      k_pipe[3] <= k_pipe[2];
      for (int r = 0; r < 3; r++) begin
        e3_acc[r] <= 53'(e2_prod[r][0]) + 53'(e2_prod[r][1]) + 53'(e2_prod[r][2]);
      end
      e3_num <= e2_base + (basis_mode ? (rot36 <<< 1) + rot36 : (rot36 <<< 1));

      // Stage 4: magnitudes.
      k_pipe[4] <= k_pipe[3];
      for (int r = 0; r < 3; r++) begin
        e4_gneg[r] <= e3_acc[r][52];
        e4_gmag[r] <= e3_acc[r][52] ? 53'(-e3_acc[r]) : 53'(e3_acc[r]);
      end
      e4_vneg <= e3_num[35];
      e4_vmag <= e3_num[35] ? 36'(-e3_num) : 36'(e3_num);

      // Stage 5: rounding offset and power-of-two part of the divide.
      k_pipe[5] <= k_pipe[4];
      e5_gneg   <= e4_gneg;
      for (int r = 0; r < 3; r++) begin
        e5_gx[r] <= cap_div(gsum[r][52:15]);
      end
      e5_vneg <= e4_vneg;
      e5_vx   <= cap_div({18'b0, vsum[35:16]});

      // Stage 6: divide by three.
      k_pipe[6] <= k_pipe[5];
      e6_gneg   <= e5_gneg;
      for (int r = 0; r < 3; r++) begin
        e6_gq[r] <= div3(e5_gx[r]);
      end
      e6_vneg <= e5_vneg;
      e6_vq   <= div3(e5_vx);

      // Stage 7: sign and saturation into the output register.
      result.basis_index <= k_pipe[6];
      result.last_basis  <= (k_pipe[6] == LAST_K);
      if (!e6_vneg) begin
        result.basis_value <= (e6_vq > VAL_MAXQ) ? 16'sh7FFF : $signed(e6_vq[15:0]);
      end else begin
        result.basis_value <= (e6_vq > VAL_MINQ) ? 16'sh8000 : $signed(-e6_vq[15:0]);
      end
      if (!e6_gneg[0]) begin
        result.grad_x <= (e6_gq[0] > GRAD_MAXQ) ? $signed(GRAD_MAXQ) : $signed(e6_gq[0]);
      end else begin
        result.grad_x <= (e6_gq[0] > GRAD_MINQ) ? $signed(GRAD_MINQ) : $signed(-e6_gq[0]);
      end
      if (!e6_gneg[1]) begin
        result.grad_y <= (e6_gq[1] > GRAD_MAXQ) ? $signed(GRAD_MAXQ) : $signed(e6_gq[1]);
      end else begin
        result.grad_y <= (e6_gq[1] > GRAD_MINQ) ? $signed(GRAD_MINQ) : $signed(-e6_gq[1]);
      end
      if (!e6_gneg[2]) begin
        result.grad_z <= (e6_gq[2] > GRAD_MAXQ) ? $signed(GRAD_MAXQ) : $signed(e6_gq[2]);
      end else begin
        result.grad_z <= (e6_gq[2] > GRAD_MINQ) ? $signed(GRAD_MINQ) : $signed(-e6_gq[2]);
      end
    end
  end

  assign result.valid = vld[7];

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Rotated Q1 basis evaluator testbench
// Sends reference points with inverse Jacobians to the core in both basis
// modes. For each transfer it works out the six basis values and physical
// gradients on its own and checks every result field in order. Both sides
// of the block idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_MEAN  = 1'b1;

  localparam longint ONE_Q14   = 16384;
  localparam longint VALUE_DEN = 12 * ONE_Q14;
  localparam longint GRAD_DEN  = 6 * ONE_Q14;
  localparam int DRAIN_CYCLES  = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PRINT_LIMIT   = 50;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_level_t;

  typedef struct packed {
    rq1b_pkg::point_t         px;
    rq1b_pkg::point_t         py;
    rq1b_pkg::point_t         pz;
    rq1b_pkg::jinv_t [8:0]    jm;
  } eval_point_t;

  typedef struct packed {
    rq1b_pkg::index_t         idx;
    rq1b_pkg::value_t         val;
    rq1b_pkg::grad_t [2:0]    grad;
    logic                     last;
  } basis_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  rq1b_item_if   item_ch ();
  rq1b_result_if result_ch ();

  rotated_q1_basis_eval_3d_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  eval_point_t   points_to_send[$];
  basis_result_t basis_results_due[$];
  eval_point_t   point_on_bus;
  logic          basis_mode_model = MODE_POINT;
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  bit            sender_gaps = 1'b1;
  stall_level_t  stall_level = STALL_LIGHT;
  int unsigned   stall_phase = 0;
  logic [31:0]   stall_bits = '1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.point_x = '0;
    item_ch.point_y = '0;
    item_ch.point_z = '0;
    item_ch.jinv_00 = '0;
    item_ch.jinv_01 = '0;
    item_ch.jinv_02 = '0;
    item_ch.jinv_10 = '0;
    item_ch.jinv_11 = '0;
    item_ch.jinv_12 = '0;
    item_ch.jinv_20 = '0;
    item_ch.jinv_21 = '0;
    item_ch.jinv_22 = '0;
    result_ch.ready = 1'b0;
  end

  function automatic longint round_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic eval_rotated_basis(eval_point_t pt);
    longint p[3];
    longint sq[3];
    longint rot[3];
    longint g[3];
    longint sumsq, kval, koff, kon, num, acc, side;
    int axis;
    basis_result_t r;
    p[0] = pt.px;
    p[1] = pt.py;
    p[2] = pt.pz;
    for (int c = 0; c < 3; c++) sq[c] = p[c] * p[c];
    sumsq = sq[0] + sq[1] + sq[2];
    for (int c = 0; c < 3; c++) rot[c] = 3 * sq[c] - sumsq;
    if (basis_mode_model == MODE_MEAN) begin
      kval = 3;
      koff = -3;
      kon = 6;
    end else begin
      kval = 2;
      koff = -2;
      kon = 4;
    end
    for (int k = 0; k < rq1b_pkg::NUM_BASIS; k++) begin
      axis = (k == 0 || k == 5) ? 2 : (k == 1 || k == 4) ? 1 : 0;
      side = (k < 3) ? -1 : 1;
      num = 2 * ONE_Q14 * ONE_Q14 + side * 6 * p[axis] * ONE_Q14 + kval * rot[axis];
      r.idx = rq1b_pkg::index_t'(k);
      r.val = rq1b_pkg::value_t'(saturate(round_half_away(num, VALUE_DEN), -32768, 32767));
      for (int c = 0; c < 3; c++)
        g[c] = (c == axis) ? side * 3 * ONE_Q14 + kon * p[c] : koff * p[c];
      for (int row = 0; row < 3; row++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) acc += longint'($signed(pt.jm[row * 3 + c])) * g[c];
        r.grad[row] = rq1b_pkg::grad_t'(saturate(round_half_away(acc, GRAD_DEN),
                                                 -64'sd2147483648, 64'sd2147483647));
      end
      r.last = (k == rq1b_pkg::NUM_BASIS - 1);
      basis_results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) eval_rotated_basis(point_on_bus);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (points_to_send.size() != 0) begin
          point_on_bus = points_to_send.pop_front();
          item_ch.point_x <= point_on_bus.px;
          item_ch.point_y <= point_on_bus.py;
          item_ch.point_z <= point_on_bus.pz;
          item_ch.jinv_00 <= point_on_bus.jm[0];
          item_ch.jinv_01 <= point_on_bus.jm[1];
          item_ch.jinv_02 <= point_on_bus.jm[2];
          item_ch.jinv_10 <= point_on_bus.jm[3];
          item_ch.jinv_11 <= point_on_bus.jm[4];
          item_ch.jinv_12 <= point_on_bus.jm[5];
          item_ch.jinv_20 <= point_on_bus.jm[6];
          item_ch.jinv_21 <= point_on_bus.jm[7];
          item_ch.jinv_22 <= point_on_bus.jm[8];
          item_ch.valid <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 8);
          burst_left--;
          if (burst_left == 0 && sender_gaps)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic signed [63:0] got,
                                 logic signed [63:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    basis_result_t want;
    if (basis_results_due.size() == 0) begin
      report_mismatch("unexpected result, basis_index", result_ch.basis_index, 0);
    end else begin
      want = basis_results_due.pop_front();
      if (result_ch.basis_index !== want.idx)
        report_mismatch("basis_index", result_ch.basis_index, want.idx);
      if (result_ch.basis_value !== want.val)
        report_mismatch("basis_value", result_ch.basis_value, want.val);
      if (result_ch.grad_x !== want.grad[0])
        report_mismatch("grad_x", result_ch.grad_x, $signed(want.grad[0]));
      if (result_ch.grad_y !== want.grad[1])
        report_mismatch("grad_y", result_ch.grad_y, $signed(want.grad[1]));
      if (result_ch.grad_z !== want.grad[2])
        report_mismatch("grad_z", result_ch.grad_z, $signed(want.grad[2]));
      if (result_ch.last_basis !== want.last)
        report_mismatch("last_basis", result_ch.last_basis, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_result();
      stall_bits = {stall_bits[0], stall_bits[31:1]};
      stall_phase++;
      if (stall_phase % 32 == 0) begin
        if (stall_level == STALL_HEAVY) stall_bits = $urandom & $urandom;
        else if ($urandom_range(0, 3) == 0) stall_bits = '1;
        else stall_bits = $urandom | $urandom;
      end
      result_ch.ready <= (stall_level == STALL_NONE) ? 1'b1 : stall_bits[0];
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("rotated_q1_basis_eval_3d_core regression: fail");
    $finish;
  end

  function automatic eval_point_t make_point(rq1b_pkg::point_t x, rq1b_pkg::point_t y,
                                             rq1b_pkg::point_t z,
                                             rq1b_pkg::jinv_t diag, rq1b_pkg::jinv_t off);
    eval_point_t pt;
    pt.px = x;
    pt.py = y;
    pt.pz = z;
    for (int i = 0; i < 9; i++) pt.jm[i] = (i % 4 == 0) ? diag : off;
    return pt;
  endfunction

  function automatic eval_point_t random_point(bit full_range);
    eval_point_t pt;
    if (full_range) begin
      pt.px = rq1b_pkg::point_t'($urandom);
      pt.py = rq1b_pkg::point_t'($urandom);
      pt.pz = rq1b_pkg::point_t'($urandom);
      for (int i = 0; i < 9; i++) pt.jm[i] = rq1b_pkg::jinv_t'($urandom);
    end else begin
      pt.px = rq1b_pkg::point_t'(int'($urandom_range(0, 32768)) - 16384);
      pt.py = rq1b_pkg::point_t'(int'($urandom_range(0, 32768)) - 16384);
      pt.pz = rq1b_pkg::point_t'(int'($urandom_range(0, 32768)) - 16384);
      for (int i = 0; i < 9; i++)
        pt.jm[i] = rq1b_pkg::jinv_t'(int'($urandom_range(0, 32'd16777216)) - 8388608);
    end
    return pt;
  endfunction

  task automatic send_item(eval_point_t pt);
    @(negedge clk);
    points_to_send.push_back(pt);
    do @(negedge clk); while (points_to_send.size() != 0);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (points_to_send.size() != 0 || item_ch.valid || basis_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_basis_mode(logic mode);
    wait_for_drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    basis_mode_model = mode;
  endtask

  task automatic send_corner_set();
    send_item(make_point(16'sd0, 16'sd0, 16'sd0, 32'sd1048576, 32'sd0));
    send_item(make_point(16'sd16384, 16'sd16384, 16'sd16384, 32'sd1048576, 32'sd0));
    send_item(make_point(-16'sd16384, -16'sd16384, -16'sd16384, 32'sd1048576, 32'sd0));
    send_item(make_point(16'sd16384, -16'sd16384, 16'sd0, 32'sd1048576, -32'sd524288));
    send_item(make_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff, 32'sh7fffffff));
    send_item(make_point(16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000, 32'sh80000000));
    send_item(make_point(16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh7fffffff, 32'sh80000000));
    send_item(make_point(16'sh8000, 16'sd0, 16'sh7fff, -32'sd1, 32'sd1));
    send_item(make_point(16'sd8192, -16'sd4096, 16'sd12000, 32'sd3145728, -32'sd1310720));
    send_item(make_point(16'sd1, -16'sd1, 16'sd0, 32'sd0, 32'sd0));
    send_item(make_point(16'sh7fff, 16'sd0, 16'sd0, 32'sd1048576, 32'sd1048576));
    send_item(make_point(16'sh8000, 16'sh7fff, 16'sh8000, 32'sh80000000, 32'sh7fffffff));
  endtask

  task automatic test_point_variant_corners();
    sender_gaps = 1'b1;
    stall_level = STALL_LIGHT;
    send_corner_set();
  endtask

  task automatic test_mean_variant_corners();
    set_basis_mode(MODE_MEAN);
    send_corner_set();
  endtask

  task automatic test_random_typical_points();
    set_basis_mode(MODE_POINT);
    sender_gaps = 1'b1;
    stall_level = STALL_LIGHT;
    repeat (30) send_item(random_point($urandom_range(0, 3) == 0));
  endtask

  task automatic test_full_range_heavy_stalls();
    set_basis_mode(MODE_MEAN);
    sender_gaps = 1'b1;
    stall_level = STALL_HEAVY;
    repeat (25) send_item(random_point($urandom_range(0, 1) == 0));
  endtask

  task automatic test_back_to_back();
    set_basis_mode(MODE_POINT);
    sender_gaps = 1'b0;
    stall_level = STALL_NONE;
    repeat (20) send_item(random_point($urandom_range(0, 3) == 0));
  endtask

  task automatic test_mode_toggling();
    sender_gaps = 1'b1;
    stall_level = STALL_LIGHT;
    for (int phase = 0; phase < 5; phase++) begin
      set_basis_mode((phase % 2 == 0) ? MODE_MEAN : MODE_POINT);
      repeat (5) send_item(random_point($urandom_range(0, 2) == 0));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_point_variant_corners();
    test_mean_variant_corners();
    test_random_typical_points();
    test_full_range_heavy_stalls();
    test_back_to_back();
    test_mode_toggling();
    wait_for_drain();
    if (basis_results_due.size() != 0)
      report_mismatch("missing results, count", basis_results_due.size(), 0);
    if (mismatch_count == 0)
      $display("rotated_q1_basis_eval_3d_core regression: pass");
    else
      $display("rotated_q1_basis_eval_3d_core regression: fail");
    $finish;
  end

endmodule
